// ===== rtl/core/nmea_rmc_time_date_extractor_macros.svh =====
// Assertion macros for the NMEA RMC time and date extractor.
// Used by files that include this header; no other dependencies.
// Assumes the including module has a clock clk and an active-low reset arst_n.
`ifndef NMEA_RMC_TIME_DATE_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_TIME_DATE_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define NRTD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("nrtd assertion failed");
// When ante holds, cons must hold in the following cycle.
`define NRTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrtd assertion failed");
`else
`define NRTD_ASSERT(label, prop)
`define NRTD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/nrtd_pkg.sv =====
// Package for the NMEA RMC time and date extractor.
// Holds the sentence phase type, character codes, field numbers and the prefix lookup; no dependencies.
`default_nettype none

package nrtd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_PREFIX = 2'd1,
		PH_FIELDS = 2'd2
	} phase_t;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	localparam logic [2:0] PREFIX_LEN = 3'd5;

	localparam logic [3:0] TIME_FIELD = 4'd1;
	localparam logic [3:0] DATE_FIELD = 4'd9;

	// Expected character of the "GPRMC" prefix at a given position.
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h47; // G
			3'd1: ch = 8'h50; // P
			3'd2: ch = 8'h52; // R
			3'd3: ch = 8'h4D; // M
			3'd4: ch = 8'h43; // C
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmea_rmc_time_date_extractor.sv =====
// Each character is captured in the input register and parsed from there; the result word of a
// closing comma is loaded into the result register as that comma leaves the input register.
// Throughput: one input character per cycle while no stall is in effect.
// The only wait comes from a full result register under out_stall when a sentence closes.
// Reset (arst_n low, asynchronous) returns the parser to idle, waiting for a dollar sign,
// and clears the captured time, date and presence flags.
// Depends on nrtd_pkg and nmea_rmc_time_date_extractor_macros.svh.
`default_nettype none

module nmea_rmc_time_date_extractor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      hours_bcd,
	output logic [7:0]      minutes_bcd,
	output logic [7:0]      seconds_bcd,
	output logic [7:0]      hundredths_bcd,
	output logic [7:0]      day_bcd,
	output logic [7:0]      month_bcd,
	output logic [7:0]      year_bcd,
	output logic            time_present,
	output logic            date_present
);
	import nrtd_pkg::*;

`include "nmea_rmc_time_date_extractor_macros.svh"

	// Input register: one received character waiting to be parsed.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	phase_t      phase_q,  phase_d;
	logic [2:0]  prefix_pos_q, prefix_pos_d;
	logic [3:0]  field_num_q,  field_num_d;
	logic [3:0]  char_pos_q,   char_pos_d;
	logic [4:0]  pend_q,       pend_d;
	logic [31:0] time_q,       time_d;
	logic [23:0] date_q,       date_d;
	logic [1:0]  flags_q,      flags_d;

	// Result register.
	logic        out_valid_q;
	logic [31:0] out_time_q;
	logic [23:0] out_date_q;
	logic [1:0]  out_flags_q;

	logic       emit;
	logic       out_free;
	logic       s1_adv;
	logic       is_digit;
	logic [3:0] dval;
	logic       is_time;
	logic       is_date;
	logic       slot_ok;
	logic       slot_first;
	logic [1:0] slot;
	logic       wr_en;
	logic [7:0] wr_val;

	// The result register can take a new word when it is empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	// A character without a result always moves on; a closing comma that emits a result needs room.
	assign s1_adv   = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !s1_adv;

	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	// ASCII digits carry their value in the low nibble.
	assign dval     = is_digit ? byte_s1[3:0] : 4'h0;
	assign is_time  = (field_num_q == TIME_FIELD);
	assign is_date  = (field_num_q == DATE_FIELD);

	// Where a character of the time or date field lands. The time field is
	// hhmmss.ss: the dot at position 6 is skipped and the hundredths pair sits
	// at positions 7 and 8. The date field is ddmmyy.
	always_comb begin
		slot_ok    = 1'b0;
		slot_first = 1'b0;
		slot       = 2'd0;
		if (is_time) begin
			if (char_pos_q <= 4'd5) begin
				slot_ok    = 1'b1;
				slot_first = !char_pos_q[0];
				slot       = 2'd3 - char_pos_q[2:1];
			end else if (char_pos_q == 4'd7 || char_pos_q == 4'd8) begin
				slot_ok    = 1'b1;
				slot_first = (char_pos_q == 4'd7);
				slot       = 2'd0;
			end
		end else if (is_date) begin
			if (char_pos_q <= 4'd5) begin
				slot_ok    = 1'b1;
				slot_first = !char_pos_q[0];
				slot       = 2'd2 - char_pos_q[2:1];
			end
		end
	end

	// Byte written into the captured value. A leading digit is stored alone at
	// once, so a pair cut short by a non-digit or the field end keeps it; a
	// leading non-digit stores zero and blocks the second character.
	always_comb begin
		wr_en  = 1'b0;
		wr_val = 8'h00;
		if (slot_ok) begin
			if (slot_first) begin
				wr_en  = 1'b1;
				wr_val = {4'h0, dval};
			end else if (pend_q[4] && is_digit) begin
				wr_en  = 1'b1;
				wr_val = {pend_q[3:0], dval};
			end
		end
	end

	// Next state of the parser for the character in the input register.
	always_comb begin
		phase_d      = phase_q;
		prefix_pos_d = prefix_pos_q;
		field_num_d  = field_num_q;
		char_pos_d   = char_pos_q;
		pend_d       = pend_q;
		time_d       = time_q;
		date_d       = date_q;
		flags_d      = flags_q;
		emit         = 1'b0;
		if (byte_s1 == CHAR_DOLLAR) begin
			// A dollar sign always starts a new sentence, even mid-sentence.
			phase_d      = PH_PREFIX;
			prefix_pos_d = 3'd0;
			field_num_d  = 4'd0;
			char_pos_d   = 4'd0;
			pend_d       = 5'd0;
			time_d       = 32'd0;
			date_d       = 24'd0;
			flags_d      = 2'b00;
		end else begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (prefix_pos_q < PREFIX_LEN && byte_s1 == prefix_char(prefix_pos_q)) begin
						prefix_pos_d = prefix_pos_q + 3'd1;
						if (prefix_pos_q == PREFIX_LEN - 3'd1) begin
							phase_d = PH_FIELDS;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_FIELDS: begin
					if (byte_s1 != CHAR_COMMA) begin
						if (is_time) begin
							flags_d[0] = 1'b1;
						end
						if (is_date) begin
							flags_d[1] = 1'b1;
						end
						if (slot_ok) begin
							if (slot_first) begin
								pend_d = is_digit ? {1'b1, dval} : 5'd0;
							end else begin
								pend_d = 5'd0;
							end
						end
						if (wr_en && is_time) begin
							time_d[{slot, 3'b000} +: 8] = wr_val;
						end
						if (wr_en && is_date) begin
							date_d[{slot, 3'b000} +: 8] = wr_val;
						end
						if (char_pos_q != 4'hF) begin
							char_pos_d = char_pos_q + 4'd1;
						end
					end else if (field_num_q >= DATE_FIELD) begin
						// The comma closing the date field ends the sentence.
						phase_d = PH_IDLE;
						emit    = (flags_q != 2'b00);
					end else begin
						field_num_d = field_num_q + 4'd1;
						char_pos_d  = 4'd0;
						pend_d      = 5'd0;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser state advances once per character leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prefix_pos_q <= 3'd0;
			field_num_q  <= 4'd0;
			char_pos_q   <= 4'd0;
			pend_q       <= 5'd0;
			time_q       <= 32'd0;
			date_q       <= 24'd0;
			flags_q      <= 2'b00;
		end else if (s1_adv) begin
			phase_q      <= phase_d;
			prefix_pos_q <= prefix_pos_d;
			field_num_q  <= field_num_d;
			char_pos_q   <= char_pos_d;
			pend_q       <= pend_d;
			time_q       <= time_d;
			date_q       <= date_d;
			flags_q      <= flags_d;
		end
	end

	// Result register: holds the word until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_time_q  <= time_q;
			out_date_q  <= date_q;
			out_flags_q <= flags_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hours_bcd      = out_time_q[31:24];
	assign minutes_bcd    = out_time_q[23:16];
	assign seconds_bcd    = out_time_q[15:8];
	assign hundredths_bcd = out_time_q[7:0];
	assign day_bcd        = out_date_q[23:16];
	assign month_bcd      = out_date_q[15:8];
	assign year_bcd       = out_date_q[7:0];
	assign time_present   = out_flags_q[0];
	assign date_present   = out_flags_q[1];

	// A result word is only produced when one of the fields was seen.
	`NRTD_ASSERT(a_result_has_field, out_valid_q |-> (out_flags_q != 2'b00))
	// The field phase is reached only through a complete prefix match.
	`NRTD_ASSERT(a_fields_after_prefix, (phase_q == PH_FIELDS) |-> (prefix_pos_q == PREFIX_LEN))
	// Field numbering never runs past the date field.
	`NRTD_ASSERT(a_field_bound, field_num_q <= DATE_FIELD)
	// Input back-pressure (only while a closing comma waits for a busy result register) keeps the character held.
	`NRTD_ASSERT_NEXT(a_stall_cause, in_stall, valid_s1)

endmodule

`default_nettype wire
